// ===== rtl/pse_pkg.sv =====
// pse_pkg: shared constants, codes, state encoding and rounding helpers
// for the particle swarm update engine; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    // swarm dimensions
    localparam int NUM_PARTICLES = 64;
    localparam int NUM_VARIABLES = 32;
    localparam int CELLS         = NUM_PARTICLES * NUM_VARIABLES;
    localparam int CELL_W        = $clog2(CELLS);
    localparam int PB_AW         = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int GB_AW         = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
    localparam int CNT_W         = $clog2(NUM_VARIABLES + 1);

    // fixed field widths
    localparam int PIDX_W = 6;
    localparam int VIDX_W = 5;
    localparam int CFGI_W = 3;

    // item kinds
    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_MOVE   = 2'd1,
        REQ_REPORT = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_CHI = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_C1  = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_C2  = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_LOF = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_HIF = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MV_DIFF,
        ST_MV_TERM,
        ST_MV_SUM,
        ST_MV_VEL,
        ST_MV_POS,
        ST_MV_LO,
        ST_MV_LOSC,
        ST_MV_HI,
        ST_MV_HISC,
        ST_MV_WB,
        ST_RP_CMP,
        ST_RP_COPY
    } state_t;

    // q32 to q16: nearest, ties toward plus infinity
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] a);
        return (a + 64'sd32768) >>> 16;
    endfunction

    // saturate to 32 bit signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        logic signed [31:0] r;
        if (a > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (a < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = a[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pso_swarm_update_engine.sv =====
// Load, read and out-of-range items finish in the fetch state; a move steps through diff, term,
// sum, vel, pos, lo, hi and wb, plus one scaling step per clamp hit; a report compares and, with
// an improvement, copies the position vector, one word copied per cycle through the position ram
// read port. One item at a time; the next start is taken no earlier than the edge that ends done.
// done is a single-cycle strobe, never stalled.
// Reset is asynchronous: control, best-valid flags and config registers return to defaults.
// pso_swarm_update_engine: top level, sequencer and move datapath
// depends on pse_pkg and pse_ram
`timescale 1ns / 1ps
`default_nettype none

module pso_swarm_update_engine
    import pse_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // item channel
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               req_type,
    input  wire logic [PIDX_W-1:0]        particle_index,
    input  wire logic [VIDX_W-1:0]        variable_index,
    input  wire logic signed [31:0]       operand_value,
    input  wire logic [15:0]              rand_one,
    input  wire logic [15:0]              rand_two,
    input  wire logic signed [31:0]       lower_limit,
    input  wire logic signed [31:0]       upper_limit,
    // configuration channel
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFGI_W-1:0]        cfg_index,
    input  wire logic [31:0]              cfg_data,
    // result channel
    output logic                          done,
    output logic signed [31:0]            position_out,
    output logic signed [31:0]            speed_out,
    output logic                          local_improved,
    output logic                          global_improved
);

    state_t state_reg, state_next;

    // captured item
    req_t                  req_reg;
    logic [PIDX_W-1:0]     p_reg;
    logic [VIDX_W-1:0]     var_reg;
    logic signed [31:0]    opnd_reg;
    logic [15:0]           r1_reg, r2_reg;
    logic signed [31:0]    lo_reg, hi_reg;

    // configuration
    logic [16:0]           chi_reg;
    logic [18:0]           c1_reg, c2_reg;
    logic signed [17:0]    lof_reg, hif_reg;

    // move datapath
    logic signed [31:0]    x_reg, v_reg;
    logic signed [32:0]    diff1_reg, diff2_reg;
    logic [19:0]           cr1_reg, cr2_reg;
    logic signed [39:0]    t1_reg, t2_reg;
    logic signed [59:0]    prod_reg;
    logic signed [32:0]    nx_reg;

    // report bookkeeping
    logic [CNT_W-1:0]      cnt_reg;
    logic                  loc_upd_reg, glb_upd_reg;
    logic [NUM_PARTICLES-1:0] pb_valid_reg;
    logic                  gb_valid_reg;
    logic signed [31:0]    gb_score_reg;
    logic signed [31:0]    gbest_reg [NUM_VARIABLES];

    // results
    logic                  done_reg;
    logic signed [31:0]    pos_out_reg, spd_out_reg;
    logic                  loc_out_reg, glb_out_reg;

    // ram ports
    logic                  pv_we, pb_we, ps_we;
    logic [CELL_W-1:0]     pv_raddr, pv_waddr, pb_waddr;
    logic [63:0]           pv_wdata, pv_rdata;
    logic [31:0]           pb_rdata, ps_rdata;

    // decoded item
    logic                  p_ok, v_ok;
    logic [CELL_W-1:0]     cell_addr, copy_rd_cell, copy_wr_cell;
    logic [GB_AW-1:0]      gvar, copy_wvar;
    logic [CNT_W-1:0]      cnt_prev;
    logic                  loc_now, glb_now;

    // result strobe and values
    logic                  fin;
    logic signed [31:0]    res_pos, res_spd;
    logic                  res_loc, res_glb;

    // move arithmetic
    logic [35:0]           crp1, crp2;
    logic signed [54:0]    tp1, tp2;
    logic signed [40:0]    sum;
    logic signed [59:0]    chi_prod, lo_prod, hi_prod;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // index decode
    assign p_ok         = (32'(p_reg) < NUM_PARTICLES);
    assign v_ok         = (32'(var_reg) < NUM_VARIABLES);
    assign cell_addr    = CELL_W'(32'(p_reg) * NUM_VARIABLES + 32'(var_reg));
    assign cnt_prev     = cnt_reg - CNT_W'(1);
    assign copy_rd_cell = CELL_W'(32'(p_reg) * NUM_VARIABLES + 32'(cnt_reg));
    assign copy_wr_cell = CELL_W'(32'(p_reg) * NUM_VARIABLES + 32'(cnt_prev));
    assign gvar         = GB_AW'(var_reg);
    assign copy_wvar    = GB_AW'(cnt_prev);

    // best-score compare
    assign loc_now = !pb_valid_reg[PB_AW'(p_reg)] || (opnd_reg < $signed(ps_rdata));
    assign glb_now = !gb_valid_reg || (opnd_reg < gb_score_reg);

    // move arithmetic
    assign crp1     = 36'(c1_reg) * 36'(r1_reg) + 36'd32768;
    assign crp2     = 36'(c2_reg) * 36'(r2_reg) + 36'd32768;
    assign tp1      = $signed({1'b0, cr1_reg}) * diff1_reg;
    assign tp2      = $signed({1'b0, cr2_reg}) * diff2_reg;
    assign sum      = 41'(v_reg) + 41'(t1_reg) + 41'(t2_reg);
    assign chi_prod = $signed({1'b0, chi_reg}) * sum;
    assign lo_prod  = v_reg * lof_reg;
    assign hi_prod  = v_reg * hif_reg;

    // position and speed store, one 64 bit word per cell
    pse_ram #(.WIDTH(64), .DEPTH(CELLS), .ADDR_W(CELL_W)) u_pv_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (pv_raddr),
        .rdata (pv_rdata)
    );

    // personal best store
    pse_ram #(.WIDTH(32), .DEPTH(CELLS), .ADDR_W(CELL_W)) u_pb_ram (
        .clk   (clk),
        .we    (pb_we),
        .waddr (pb_waddr),
        .wdata (pv_rdata[63:32]),
        .raddr (cell_addr),
        .rdata (pb_rdata)
    );

    // personal best score
    pse_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES), .ADDR_W(PB_AW)) u_ps_ram (
        .clk   (clk),
        .we    (ps_we),
        .waddr (PB_AW'(p_reg)),
        .wdata (opnd_reg),
        .raddr (PB_AW'(p_reg)),
        .rdata (ps_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_FETCH;
            ST_FETCH:
                if (req_reg == REQ_MOVE && p_ok && v_ok)
                    state_next = ST_MV_DIFF;
                else if (req_reg == REQ_REPORT && p_ok)
                    state_next = ST_RP_CMP;
                else
                    state_next = ST_IDLE;
            ST_MV_DIFF: state_next = ST_MV_TERM;
            ST_MV_TERM: state_next = ST_MV_SUM;
            ST_MV_SUM:  state_next = ST_MV_VEL;
            ST_MV_VEL:  state_next = ST_MV_POS;
            ST_MV_POS:  state_next = ST_MV_LO;
            ST_MV_LO:
                state_next = (nx_reg < 33'(lo_reg)) ? ST_MV_LOSC : ST_MV_HI;
            ST_MV_LOSC: state_next = ST_MV_HI;
            ST_MV_HI:
                state_next = (nx_reg > 33'(hi_reg)) ? ST_MV_HISC : ST_MV_WB;
            ST_MV_HISC: state_next = ST_MV_WB;
            ST_MV_WB:   state_next = ST_IDLE;
            ST_RP_CMP:
                state_next = (loc_now || glb_now) ? ST_RP_COPY : ST_IDLE;
            ST_RP_COPY:
                if (32'(cnt_reg) == NUM_VARIABLES)
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: ram controls and result values
    always_comb
    begin
        pv_we    = 1'b0;
        pv_raddr = cell_addr;
        pv_waddr = cell_addr;
        pv_wdata = {nx_reg[31:0], v_reg};
        pb_we    = 1'b0;
        pb_waddr = copy_wr_cell;
        ps_we    = 1'b0;
        fin      = 1'b0;
        res_pos  = '0;
        res_spd  = '0;
        res_loc  = 1'b0;
        res_glb  = 1'b0;
        case (state_reg)
            ST_FETCH:
            begin
                if (req_reg == REQ_LOAD)
                begin
                    pv_we    = p_ok && v_ok;
                    pv_wdata = {opnd_reg, 32'd0};
                    fin      = 1'b1;
                end
                else if (req_reg == REQ_READ)
                begin
                    fin     = 1'b1;
                    res_pos = v_ok ? gbest_reg[gvar] : '0;
                end
                else if (req_reg == REQ_MOVE)
                    fin = !(p_ok && v_ok);
                else
                    fin = !p_ok;
            end
            ST_MV_WB:
            begin
                pv_we   = 1'b1;
                fin     = 1'b1;
                res_pos = nx_reg[31:0];
                res_spd = v_reg;
            end
            ST_RP_CMP:
            begin
                ps_we = loc_now;
                fin   = !(loc_now || glb_now);
            end
            ST_RP_COPY:
            begin
                pv_raddr = copy_rd_cell;
                pb_we    = (cnt_reg != '0) && loc_upd_reg;
                if (32'(cnt_reg) == NUM_VARIABLES)
                begin
                    fin     = 1'b1;
                    res_loc = loc_upd_reg;
                    res_glb = glb_upd_reg;
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            pb_valid_reg <= '0;
            gb_valid_reg <= 1'b0;
            gb_score_reg <= '0;
            chi_reg      <= 17'd47828;
            c1_reg       <= 19'd134349;
            c2_reg       <= 19'd134349;
            lof_reg      <= 18'sd65536;
            hif_reg      <= 18'sd65536;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            // configuration beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CHI: chi_reg <= cfg_data[16:0];
                    CFG_C1:  c1_reg  <= cfg_data[18:0];
                    CFG_C2:  c2_reg  <= cfg_data[18:0];
                    CFG_LOF: lof_reg <= $signed(cfg_data[17:0]);
                    CFG_HIF: hif_reg <= $signed(cfg_data[17:0]);
                    default: ;
                endcase
            end
            // best scores taken on improvement
            if (state_reg == ST_RP_CMP)
            begin
                if (loc_now)
                    pb_valid_reg[PB_AW'(p_reg)] <= 1'b1;
                if (glb_now)
                begin
                    gb_valid_reg <= 1'b1;
                    gb_score_reg <= opnd_reg;
                end
            end
        end
    end

    // item capture, datapath and result registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg  <= req_t'(req_type);
            p_reg    <= particle_index;
            var_reg  <= variable_index;
            opnd_reg <= operand_value;
            r1_reg   <= rand_one;
            r2_reg   <= rand_two;
            lo_reg   <= lower_limit;
            hi_reg   <= upper_limit;
        end
        if (fin)
        begin
            pos_out_reg <= res_pos;
            spd_out_reg <= res_spd;
            loc_out_reg <= res_loc;
            glb_out_reg <= res_glb;
        end
        case (state_reg)
            ST_MV_DIFF:
            begin
                x_reg     <= $signed(pv_rdata[63:32]);
                v_reg     <= $signed(pv_rdata[31:0]);
                diff1_reg <= 33'($signed(pb_rdata)) - 33'($signed(pv_rdata[63:32]));
                diff2_reg <= 33'(gbest_reg[gvar]) - 33'($signed(pv_rdata[63:32]));
                cr1_reg   <= crp1[35:16];
                cr2_reg   <= crp2[35:16];
            end
            ST_MV_TERM:
            begin
                t1_reg <= 40'(rnd16(64'(tp1)));
                t2_reg <= 40'(rnd16(64'(tp2)));
            end
            ST_MV_SUM:  prod_reg <= chi_prod;
            ST_MV_VEL:  v_reg    <= sat32(rnd16(64'(prod_reg)));
            ST_MV_POS:  nx_reg   <= 33'(x_reg) + 33'(v_reg);
            ST_MV_LO:
                if (nx_reg < 33'(lo_reg))
                begin
                    nx_reg   <= 33'(lo_reg);
                    prod_reg <= lo_prod;
                end
            ST_MV_LOSC: v_reg <= sat32(rnd16(64'(prod_reg)));
            ST_MV_HI:
                if (nx_reg > 33'(hi_reg))
                begin
                    nx_reg   <= 33'(hi_reg);
                    prod_reg <= hi_prod;
                end
            ST_MV_HISC: v_reg <= sat32(rnd16(64'(prod_reg)));
            ST_RP_CMP:
            begin
                loc_upd_reg <= loc_now;
                glb_upd_reg <= glb_now;
                cnt_reg     <= '0;
            end
            ST_RP_COPY:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg != '0 && glb_upd_reg)
                    gbest_reg[copy_wvar] <= $signed(pv_rdata[63:32]);
            end
            default: ;
        endcase
    end

    assign done            = done_reg;
    assign position_out    = pos_out_reg;
    assign speed_out       = spd_out_reg;
    assign local_improved  = loc_out_reg;
    assign global_improved = glb_out_reg;

    // store writes only happen while an item is in flight
    a_pv_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pv_we |-> busy)
        else $error("position store written while idle");

    // a result always closes an item
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item");

    // improvement flags never come with a position or speed
    a_flags_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (local_improved || global_improved)) |->
            (position_out == 32'sd0 && speed_out == 32'sd0))
        else $error("report result carries move data");

    // copy counter stays within the vector
    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RP_COPY) |-> (32'(cnt_reg) <= NUM_VARIABLES))
        else $error("copy walked past the vector");

endmodule

`default_nettype wire

// ===== rtl/pse_ram.sv =====
// pse_ram: simple dual port synchronous ram, one write and one read port,
// registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pse_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
